@@ sv/fpa_pkg.sv @@
// Shared types for the fixed-point ALU: opcodes, beat payloads and command kinds.
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_INC      = 4'd4,
    OP_DEC      = 4'd5,
    OP_GT       = 4'd6,
    OP_LT       = 4'd7,
    OP_GE       = 4'd8,
    OP_LE       = 4'd9,
    OP_EQ       = 4'd10,
    OP_NE       = 4'd11,
    OP_MIN      = 4'd12,
    OP_MAX      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    KIND_ALU,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  typedef struct packed {
    op_e                opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_raw;
    logic               compare_true;
    logic               divide_by_zero;
  } out_t;

  typedef struct packed {
    kind_e kind;
    in_t   item;
  } cmd_t;

endpackage

@@ sv/fpa_fifo.sv @@
// Small first-in first-out queue of register entries.
module fpa_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ sv/fpa_front.sv @@
// Front end: accept input beats and classify them by execution unit.
module fpa_front (
  input  logic         push_i,
  input  fpa_pkg::in_t item_i,
  output logic         full_o,
  output logic         cmd_push_o,
  output fpa_pkg::cmd_t cmd_o,
  input  logic         cmd_full_i
);
  import fpa_pkg::*;

  kind_e kind;

  always_comb begin
    unique case (item_i.opcode)
      OP_MUL:  kind = KIND_MUL;
      OP_DIV:  kind = KIND_DIV;
      default: kind = KIND_ALU;
    endcase
  end

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i;
  assign cmd_o      = '{kind: kind, item: item_i};

endmodule

@@ sv/fpa_back.sv @@
// Back end: simple ops, 32x32 multiply and a pipelined restoring divider in lockstep.
module fpa_back #(
  parameter int unsigned FractionBits = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  fpa_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_push_o,
  output fpa_pkg::out_t res_o,
  input  logic          res_full_i
);
  import fpa_pkg::*;

  localparam int unsigned DW = 32 + FractionBits;

  typedef struct packed {
    logic               valid;
    kind_e              kind;
    logic [31:0]        res;
    logic               cmp;
    logic               dz;
    logic signed [63:0] prod;
    logic               neg;
    logic [31:0]        rem;
    logic [DW-1:0]      dq;
    logic [31:0]        dsr;
  } stage_t;

  stage_t pipe_q [DW+1];
  stage_t pipe_d [DW+1];
  logic   en;

  logic signed [31:0] a, b;
  logic [31:0]        mag_a;
  logic [DW-1:0]      quo;
  logic [DW-1:0]      squo;
  logic signed [63:0] prod_sh;

  assign en        = !(pipe_q[DW].valid && res_full_i);
  assign cmd_pop_o = en && cmd_valid_i;
  assign a         = cmd_i.item.operand_a;
  assign b         = cmd_i.item.operand_b;
  assign mag_a     = a[31] ? 32'(-a) : 32'(a);

  always_comb begin
    pipe_d[0]       = '0;
    pipe_d[0].valid = cmd_valid_i;
    pipe_d[0].kind  = cmd_i.kind;
    pipe_d[0].prod  = a * b;
    pipe_d[0].neg   = a[31] ^ b[31];
    pipe_d[0].dz    = (cmd_i.item.opcode == OP_DIV) && (b == '0);
    pipe_d[0].dq    = {mag_a, {FractionBits{1'b0}}};
    pipe_d[0].dsr   = b[31] ? 32'(-b) : 32'(b);
    unique case (cmd_i.item.opcode)
      OP_ADD:      pipe_d[0].res = 32'(a + b);
      OP_SUB:      pipe_d[0].res = 32'(a - b);
      OP_INC:      pipe_d[0].res = 32'(a + 32'sd1);
      OP_DEC:      pipe_d[0].res = 32'(a - 32'sd1);
      OP_GT:       pipe_d[0].cmp = (a > b);
      OP_LT:       pipe_d[0].cmp = (a < b);
      OP_GE:       pipe_d[0].cmp = (a >= b);
      OP_LE:       pipe_d[0].cmp = (a <= b);
      OP_EQ:       pipe_d[0].cmp = (a == b);
      OP_NE:       pipe_d[0].cmp = (a != b);
      OP_MIN:      pipe_d[0].res = (a < b) ? a : b;
      OP_MAX:      pipe_d[0].res = (a > b) ? a : b;
      OP_FROM_INT: pipe_d[0].res = 32'(a <<< FractionBits);
      OP_TO_INT:   pipe_d[0].res = 32'(a >>> FractionBits);
      default:     pipe_d[0].res = '0;
    endcase
  end

  for (genvar i = 1; i <= DW; i++) begin : g_step
    logic [32:0] r33;
    logic        ge;
    always_comb begin
      r33       = {pipe_q[i-1].rem, pipe_q[i-1].dq[DW-1]};
      ge        = (r33 >= {1'b0, pipe_q[i-1].dsr});
      pipe_d[i] = pipe_q[i-1];
      pipe_d[i].rem = ge ? 32'(r33 - {1'b0, pipe_q[i-1].dsr}) : r33[31:0];
      pipe_d[i].dq  = {pipe_q[i-1].dq[DW-2:0], ge};
    end
  end

  for (genvar i = 0; i <= DW; i++) begin : g_pipe
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_q[i].valid <= 1'b0;
      end else if (en) begin
        pipe_q[i] <= pipe_d[i];
      end
    end
  end

  assign quo     = pipe_q[DW].dq;
  assign squo    = pipe_q[DW].neg ? DW'(-quo) : quo;
  assign prod_sh = pipe_q[DW].prod >>> FractionBits;

  always_comb begin
    res_o.compare_true   = pipe_q[DW].cmp;
    res_o.divide_by_zero = pipe_q[DW].dz;
    unique case (pipe_q[DW].kind)
      KIND_MUL: res_o.result_raw = prod_sh[31:0];
      KIND_DIV: res_o.result_raw = pipe_q[DW].dz ? '0 : squo[31:0];
      KIND_ALU: res_o.result_raw = pipe_q[DW].res;
      default:  res_o.result_raw = '0;
    endcase
  end

  assign res_push_o = en && pipe_q[DW].valid;

  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.divide_by_zero |-> res_o.result_raw == '0)
    else $error("divide by zero beat carries a nonzero result");

  a_cmp_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.compare_true |-> res_o.result_raw == '0)
    else $error("compare beat carries a nonzero result");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(pipe_q[DW]))
    else $error("last stage moved while stalled");

endmodule

@@ sv/fixed_point_alu_unit.sv @@
// Signed Q(32-F).F fixed-point ALU: add, sub, mul, div, inc, dec, compares, min, max,
// integer conversion. Takes one beat per cycle while full is low and delivers results
// in order, one per cycle while pop keeps up. Every operation runs through the same
// lockstep pipeline, whose length is set by the restoring divider at one quotient bit
// per stage: a result passes through the command queue, the operand stage,
// 32 + FRACTION_BITS divider stages and the result queue. Division by zero yields 0
// with divide_by_zero set; full rises when the command queue fills during a stall.
module fixed_point_alu_unit #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  fpa_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output fpa_pkg::out_t out_data_o
);
  import fpa_pkg::*;

  logic  cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t  cmd_in, cmd_head;
  logic  res_push, res_full;
  out_t  res_in;

  fpa_front u_front (
    .push_i     (push),
    .item_i     (in_data_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  fpa_fifo #(.Width($bits(cmd_t)), .Depth(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  fpa_back #(.FractionBits(FRACTION_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  fpa_fifo #(.Width($bits(out_t)), .Depth(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_data_o),
    .empty_o (empty)
  );

endmodule
